/* design/ray_box_face_intersect_top_assert.svh */
// assertion macros for the ray box face intersect block
`ifndef RAY_BOX_FACE_INTERSECT_TOP_ASSERT_SVH
`define RAY_BOX_FACE_INTERSECT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RBFI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RBFI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RBFI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RBFI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/rbfi_pkg.sv */
// shared types and constants for the ray box face intersect block
package rbfi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_FACES      = 6;
	localparam int PADDR_W        = 6;

	// register index of the tolerance register
	localparam logic [2:0] REG_EPS = 3'd6;
	localparam logic [15:0] EPS_RESET = 16'd16;

	// command codes
	localparam logic CMD_RAY   = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	// point location codes
	localparam logic [1:0] LOC_OUTSIDE = 2'd0;
	localparam logic [1:0] LOC_SURFACE = 2'd1;
	localparam logic [1:0] LOC_INSIDE  = 2'd2;

	typedef logic [63:0] plane_t;
	typedef logic signed [15:0] q16_t;

endpackage

/* design/ray_box_face_intersect_top.sv */
// ray and point queries against a box of six planes, on one shared multiplier
//
// input channel (in_valid/in_ready) takes one query transaction: cmd 0 is a
// ray query, cmd 1 a point query. the output channel (out_valid/out_ready)
// returns one or more result transactions per query, the final one with last.
// a ray query gives one result per face hit, face 5 down to face 0, or one
// result with hit clear. a point query gives one result with location.
// the planes and the tolerance sit behind an apb port; they are to be written
// only while idle, which the block itself does not enforce. every product
// goes through one 25x16 multiplier; the product is registered, then
// accumulated. a ray query drops a parallel face after its dot product;
// a face that reaches the containment test has passed the 48-step restoring
// divider or its overflow check, then takes up to 30 products in the five
// containment checks. one query is worked on at a time; in_ready is high
// only when the sequencer is idle. a finished result waits in the output
// register while the next query is taken; when the receiver stalls the
// sequencer holds at its next result until the output register is free.
// reset clears the planes to zero, the tolerance to 16 and all control state.
module ray_box_face_intersect_top #(
	parameter int COORD_BITS = rbfi_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// query channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic signed [15:0]               pos_x,
	input  logic signed [15:0]               pos_y,
	input  logic signed [15:0]               pos_z,
	input  logic signed [15:0]               dir_x,
	input  logic signed [15:0]               dir_y,
	input  logic signed [15:0]               dir_z,
	input  logic [31:0]                      max_dist,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic [2:0]                       face_index,
	output logic [30:0]                      distance,
	output logic signed [15:0]               norm_x,
	output logic signed [15:0]               norm_y,
	output logic signed [15:0]               norm_z,
	output logic [1:0]                       location,
	output logic                             last,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rbfi_pkg::PADDR_W-1:0]     paddr,
	input  logic [63:0]                      pwdata,
	output logic [63:0]                      prdata,
	output logic                             pready
);
	import rbfi_pkg::*;

	`include "ray_box_face_intersect_top_assert.svh"

	localparam int POS_W = (COORD_BITS < 16) ? COORD_BITS : 16;

	typedef enum logic [4:0] {
		S_IDLE, S_RDOT, S_RCHK, S_SDOT, S_DIVSET, S_DIV, S_TCHK, S_CMUL, S_CSET,
		S_QINIT, S_QMUL, S_QCHK, S_HIT, S_NEXT, S_PINIT, S_PCHK, S_PDONE, S_DONE
	} state_t;

	state_t              state_q;
	plane_t              plane_q [NUM_FACES];
	logic [15:0]         eps_q;
	logic                cmd_q;
	logic signed [15:0]  p_q [3];
	logic signed [15:0]  d_q [3];
	logic [31:0]         maxd_q;
	logic [2:0]          face_q;
	logic [2:0]          j_q;
	logic [1:0]          ck_q;
	logic [2:0]          mstep_q;
	logic                mph_q;
	logic signed [65:0]  acc_q;
	logic signed [40:0]  prod_q;
	logic                r_neg_q;
	logic                t_neg_q;
	logic [32:0]         den_q;
	logic [32:0]         rem_q;
	logic [47:0]         dq_q;
	logic [5:0]          divcnt_q;
	logic [48:0]         t_q;
	logic [46:0]         tc_q;
	logic [30:0]         dist_q;
	logic signed [47:0]  c_q [3];
	logic                touch_q;
	logic [1:0]          loc_q;
	// pending hit, held until the next hit or the end of the query
	logic                pend_q;
	logic [2:0]          pface_q;
	logic [30:0]         pdist_q;
	logic signed [15:0]  pnorm_q [3];
	// output register
	logic                out_valid_q;
	logic                hit_q;
	logic [2:0]          face_index_q;
	logic [30:0]         distance_q;
	logic signed [15:0]  onorm_q [3];
	logic [1:0]          location_q;
	logic                last_q;

	// shared read indices into the planes and the coordinate vectors
	logic [2:0]          pidx;
	logic [1:0]          kk;
	plane_t              pw;
	logic signed [15:0]  n_sel;
	logic signed [15:0]  off_sel;
	logic signed [15:0]  p_sel;
	logic signed [15:0]  d_sel;
	logic signed [47:0]  c_sel;
	logic signed [24:0]  mul_a;
	logic signed [15:0]  mul_b;
	logic                mul_sh;
	logic [2:0]          mlast;
	logic signed [65:0]  eps_w;
	logic signed [65:0]  abs_acc;
	logic                out_free;
	logic                out_load;
	logic [32:0]         s_abs;
	logic                div_ovf;
	logic [33:0]         trial;
	logic                trial_ge;
	logic [47:0]         dq_next;
	logic signed [65:0]  c_sum;
	logic signed [47:0]  c_clamp;
	logic [2:0]          j_nxt;
	logic [2:0]          j_first;
	logic [48:0]         maxd_w;
	logic [48:0]         eps_t;
	logic                t_skip;
	logic [1:0]          loc_end;
	logic                cfg_wr;
	logic [2:0]          cfg_idx;

	// operand selection
	always_comb begin
		unique case (state_q)
			S_QINIT, S_QMUL, S_QCHK: pidx = j_q;
			default:                 pidx = face_q;
		endcase
		unique case (state_q)
			S_CMUL, S_CSET: kk = ck_q;
			S_QMUL:         kk = mstep_q[2:1];
			default:        kk = mstep_q[1:0];
		endcase
		pw      = plane_q[pidx];
		n_sel   = signed'(pw[16*kk +: 16]);
		off_sel = signed'(pw[63:48]);
		p_sel   = p_q[kk];
		d_sel   = d_q[kk];
		c_sel   = c_q[kk];
		mul_a   = 25'(n_sel);
		mul_b   = d_sel;
		mul_sh  = 1'b0;
		mlast   = 3'd2;
		unique case (state_q)
			S_SDOT: begin
				mul_b = p_sel;
			end
			S_CMUL: begin
				mul_a  = mstep_q[0] ? signed'({2'b0, tc_q[46:24]})
				                    : signed'({1'b0, tc_q[23:0]});
				mul_sh = mstep_q[0];
				mlast  = 3'd1;
			end
			S_QMUL: begin
				mul_a  = mstep_q[0] ? 25'(signed'(c_sel[47:24]))
				                    : signed'({1'b0, c_sel[23:0]});
				mul_b  = n_sel;
				mul_sh = mstep_q[0];
				mlast  = 3'd5;
			end
			default: begin
			end
		endcase
	end

	// compare helpers
	always_comb begin
		eps_w    = signed'(66'(eps_q));
		abs_acc  = acc_q[65] ? -acc_q : acc_q;
		out_free = !out_valid_q || out_ready;
		s_abs    = abs_acc[32:0];
		// quotient needs more than 48 bits
		div_ovf  = {28'b0, s_abs} >= {den_q, 28'b0};
		trial    = {rem_q, dq_q[47]};
		trial_ge = trial >= {1'b0, den_q};
		dq_next  = {dq_q[46:0], trial_ge};
		// hit point on one axis, clamped
		c_sum    = (66'(p_sel) <<< 8) + (acc_q >>> 12);
		if (c_sum > (66'sd1 <<< 46))
			c_clamp = 48'sh4000_0000_0000;
		else if (c_sum < -(66'sd1 <<< 46))
			c_clamp = -48'sh4000_0000_0000;
		else
			c_clamp = c_sum[47:0];
		j_nxt   = ((j_q + 3'd1) == face_q) ? (j_q + 3'd2) : (j_q + 3'd1);
		j_first = (face_q == 3'd0) ? 3'd1 : 3'd0;
		maxd_w  = 49'(maxd_q);
		eps_t   = 49'(eps_q);
		t_skip  = (t_neg_q && (t_q != '0)) || (t_q < eps_t) ||
		          ((maxd_q != '0) && ((t_q > maxd_w) || ((maxd_w - t_q) < eps_t)));
		loc_end = touch_q ? LOC_SURFACE : LOC_INSIDE;
	end

	// a result transaction enters the output register
	assign out_load = out_free && (((state_q == S_HIT) && pend_q) ||
	                  (state_q == S_DONE) || (state_q == S_PDONE));

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FACES; i++)
				plane_q[i] <= '0;
			eps_q <= EPS_RESET;
		end else if (cfg_wr) begin
			if (cfg_idx == REG_EPS)
				eps_q <= pwdata[15:0];
			else if (cfg_idx < REG_EPS)
				plane_q[cfg_idx] <= pwdata;
		end
	end

	// register readback
	always_comb begin
		if (cfg_idx == REG_EPS)
			prdata = 64'(eps_q);
		else if (cfg_idx < REG_EPS)
			prdata = plane_q[cfg_idx];
		else
			prdata = '0;
	end
	assign pready = 1'b1;

	// sequencer, shared multiply-accumulate, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= '0;
			mph_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			face_q      <= '0;
			j_q         <= '0;
			ck_q        <= '0;
			divcnt_q    <= '0;
			touch_q     <= 1'b0;
			cmd_q       <= CMD_RAY;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						p_q[0]  <= 16'(signed'(pos_x[POS_W-1:0]));
						p_q[1]  <= 16'(signed'(pos_y[POS_W-1:0]));
						p_q[2]  <= 16'(signed'(pos_z[POS_W-1:0]));
						d_q[0]  <= dir_x;
						d_q[1]  <= dir_y;
						d_q[2]  <= dir_z;
						maxd_q  <= max_dist;
						touch_q <= 1'b0;
						mstep_q <= '0;
						mph_q   <= 1'b0;
						if (cmd == CMD_POINT) begin
							face_q  <= 3'd0;
							state_q <= S_PINIT;
						end else begin
							face_q  <= 3'd5;
							acc_q   <= '0;
							state_q <= S_RDOT;
						end
					end
				end
				S_RDOT, S_SDOT, S_CMUL, S_QMUL: begin
					if (!mph_q) begin
						prod_q <= mul_a * mul_b;
						mph_q  <= 1'b1;
					end else begin
						acc_q <= acc_q + (mul_sh ? (66'(prod_q) <<< 24) : 66'(prod_q));
						mph_q <= 1'b0;
						if (mstep_q == mlast) begin
							mstep_q <= '0;
							unique case (state_q)
								S_RDOT:  state_q <= S_RCHK;
								S_SDOT:  state_q <= (cmd_q == CMD_POINT) ? S_PCHK : S_DIVSET;
								S_CMUL:  state_q <= S_CSET;
								default: state_q <= S_QCHK;
							endcase
						end else begin
							mstep_q <= mstep_q + 3'd1;
						end
					end
				end
				// parallel test on r
				S_RCHK: begin
					if ((acc_q == '0) || (abs_acc < (eps_w <<< 10))) begin
						state_q <= S_NEXT;
					end else begin
						den_q   <= abs_acc[32:0];
						r_neg_q <= acc_q[65];
						acc_q   <= 66'(off_sel) <<< 14;
						state_q <= S_SDOT;
					end
				end
				// set up t = -s * 2^20 / r on magnitudes
				S_DIVSET: begin
					t_neg_q <= (acc_q != '0) && (acc_q[65] == r_neg_q);
					if (div_ovf) begin
						t_q     <= 49'(1) << 48;
						state_q <= S_TCHK;
					end else begin
						rem_q    <= 33'(s_abs[32:28]);
						dq_q     <= {s_abs[27:0], 20'b0};
						divcnt_q <= 6'd47;
						state_q  <= S_DIV;
					end
				end
				// one quotient bit per cycle
				S_DIV: begin
					rem_q <= trial_ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
					dq_q  <= dq_next;
					if (divcnt_q == '0) begin
						t_q     <= {1'b0, dq_next};
						state_q <= S_TCHK;
					end else begin
						divcnt_q <= divcnt_q - 6'd1;
					end
				end
				// range of t
				S_TCHK: begin
					if (t_skip) begin
						state_q <= S_NEXT;
					end else begin
						tc_q    <= (t_q > (49'(1) << 46)) ? (47'(1) << 46) : t_q[46:0];
						dist_q  <= (t_q > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : t_q[30:0];
						ck_q    <= 2'd0;
						acc_q   <= '0;
						state_q <= S_CMUL;
					end
				end
				// hit point coordinate
				S_CSET: begin
					c_q[ck_q] <= c_clamp;
					acc_q     <= '0;
					if (ck_q == 2'd2) begin
						j_q     <= j_first;
						state_q <= S_QINIT;
					end else begin
						ck_q    <= ck_q + 2'd1;
						state_q <= S_CMUL;
					end
				end
				S_QINIT: begin
					acc_q   <= 66'(off_sel) <<< 22;
					state_q <= S_QMUL;
				end
				// containment against face j
				S_QCHK: begin
					if (acc_q < -(eps_w <<< 14)) begin
						state_q <= S_NEXT;
					end else if (j_nxt > 3'd5) begin
						state_q <= S_HIT;
					end else begin
						j_q     <= j_nxt;
						state_q <= S_QINIT;
					end
				end
				// older pending hit goes out, this one waits
				S_HIT: begin
					if (!pend_q || out_free) begin
						if (pend_q) begin
							hit_q        <= 1'b1;
							face_index_q <= pface_q;
							distance_q   <= pdist_q;
							onorm_q      <= pnorm_q;
							location_q   <= LOC_OUTSIDE;
							last_q       <= 1'b0;
						end
						pend_q     <= 1'b1;
						pface_q    <= face_q;
						pdist_q    <= dist_q;
						pnorm_q[0] <= 16'(-signed'(pw[15:0]));
						pnorm_q[1] <= 16'(-signed'(pw[31:16]));
						pnorm_q[2] <= 16'(-signed'(pw[47:32]));
						state_q    <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (face_q == 3'd0) begin
						state_q <= S_DONE;
					end else begin
						face_q  <= face_q - 3'd1;
						acc_q   <= '0;
						state_q <= S_RDOT;
					end
				end
				// final ray result
				S_DONE: begin
					if (out_free) begin
						hit_q        <= pend_q;
						face_index_q <= pend_q ? pface_q : 3'd0;
						distance_q   <= pend_q ? pdist_q : 31'd0;
						onorm_q[0]   <= pend_q ? pnorm_q[0] : 16'sd0;
						onorm_q[1]   <= pend_q ? pnorm_q[1] : 16'sd0;
						onorm_q[2]   <= pend_q ? pnorm_q[2] : 16'sd0;
						location_q   <= LOC_OUTSIDE;
						last_q       <= 1'b1;
						pend_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_PINIT: begin
					acc_q   <= 66'(off_sel) <<< 14;
					state_q <= S_SDOT;
				end
				// point classification against one face
				S_PCHK: begin
					if (abs_acc < (eps_w <<< 6)) begin
						touch_q <= 1'b1;
						if (face_q == 3'd5) begin
							loc_q   <= LOC_SURFACE;
							state_q <= S_PDONE;
						end else begin
							face_q  <= face_q + 3'd1;
							state_q <= S_PINIT;
						end
					end else if (acc_q[65]) begin
						loc_q   <= LOC_OUTSIDE;
						state_q <= S_PDONE;
					end else if (face_q == 3'd5) begin
						loc_q   <= loc_end;
						state_q <= S_PDONE;
					end else begin
						face_q  <= face_q + 3'd1;
						state_q <= S_PINIT;
					end
				end
				S_PDONE: begin
					if (out_free) begin
						hit_q        <= 1'b0;
						face_index_q <= 3'd0;
						distance_q   <= 31'd0;
						onorm_q[0]   <= 16'sd0;
						onorm_q[1]   <= 16'sd0;
						onorm_q[2]   <= 16'sd0;
						location_q   <= loc_q;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign face_index = face_index_q;
	assign distance   = distance_q;
	assign norm_x     = onorm_q[0];
	assign norm_y     = onorm_q[1];
	assign norm_z     = onorm_q[2];
	assign location   = location_q;
	assign last       = last_q;

	// a new query never starts with a hit left over
	`RBFI_ASSERT_IMP(a_no_stale_pend, clk, arst_n, in_valid && in_ready, !pend_q, "stale hit")
	// once a query is taken the block is busy
	`RBFI_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "not busy")
	// restoring divider keeps the remainder below the divisor
	`RBFI_ASSERT_IMP(a_div_rem, clk, arst_n, state_q == S_DIV, rem_q < den_q, "bad remainder")

endmodule
